### design/eftd_pkg.sv
package eftd_pkg;

    localparam int MAX_RESOURCES = 8;
    localparam int NUM_TYPES     = 4;

    localparam int TIME_W     = 48;
    localparam int EXEC_W     = 32;
    localparam int TYPE_W     = 2;
    localparam int MAP_W      = 16;
    localparam int COUNT_W    = 4;
    localparam int RIDX_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // resource index and loop counter widths follow the resource count
    localparam int RES_W = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int CNT_W = $clog2(MAX_RESOURCES + 1);

    // digit-serial datapath
    localparam int DIG_W     = 16;
    localparam int N_DIG     = TIME_W / DIG_W;
    localparam int DIG_CNT_W = (N_DIG > 1) ? $clog2(N_DIG) : 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESOURCES_IN_USE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESOURCE_TYPE_MAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUEING_ENABLE   = 2'd2;

    // opcodes
    localparam logic OP_SCHEDULE = 1'b0;
    localparam logic OP_FINISH   = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [TIME_W-1:0] now_time;
        logic [3:0]        supported_mask;
        logic [EXEC_W-1:0] exec_time_type0;
        logic [EXEC_W-1:0] exec_time_type1;
        logic [EXEC_W-1:0] exec_time_type2;
        logic [EXEC_W-1:0] exec_time_type3;
        logic [RIDX_W-1:0] finished_resource;
    } in_item_t;

    typedef struct packed {
        logic              assigned;
        logic [RIDX_W-1:0] chosen_res;
        logic [TIME_W-1:0] end_time;
    } out_item_t;

endpackage

### design/earliest_finish_task_dispatch_unit.sv
// Earliest-finish-time task dispatcher. Each input transfer is either a
// schedule request (one ready task with its supported type mask, per-type
// execution time and the present time) or a finish report that clears one
// resource's busy mark. For a schedule request the unit walks the resources
// in use from the highest index down, and for each one whose type the task
// supports forms max(avail, now) + exec on a 16-bit digit-serial datapath:
// the availability time is compared against the present time, least
// significant digit first, then the execution time is added and the sum is
// compared against the best finish so far. Ties keep the higher
// index. The winner's availability becomes the finish time, saturated to
// 48 bits, and it is marked busy; with queueing disabled a busy winner
// refuses the task and nothing changes. Every request yields exactly one
// result transfer. The pace of schedule requests is set by the single 16-bit
// add/compare digit unit that every supported resource passes through. A
// finished result waits in the output register while the next request is
// already being worked on. Configuration is written through a plain write
// port (no read-back) and must only be changed while the unit is idle.
module earliest_finish_task_dispatch_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  eftd_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output eftd_pkg::out_item_t               out_data,
    input  logic                              cfg_we,
    input  logic [eftd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [eftd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import eftd_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // Type of resource r; resources past the map's bits read as type 0.
    function automatic logic [TYPE_W-1:0] type_of(input logic [MAP_W-1:0] map,
                                                  input logic [RES_W-1:0] r);
        logic [MAP_W-1:0] sh;
        sh = map >> (TYPE_W * 32'(r));
        if (32'(r) >= MAP_W / TYPE_W)
        begin
            return '0;
        end
        return sh[TYPE_W-1:0];
    endfunction

    // ---------------- configuration ----------------
    logic [COUNT_W-1:0] res_in_use_reg;
    logic [MAP_W-1:0]   type_map_reg;
    logic               queue_en_reg;

    // ---------------- control state ----------------
    logic [2:0]           state_reg,  state_next;
    logic [CNT_W-1:0]     cnt_reg,    cnt_next;
    logic [DIG_CNT_W-1:0] dig_reg,    dig_next;
    logic                 lt_reg,     lt_next;     // avail < now so far
    logic                 ltb_reg,    ltb_next;    // new sum < best so far
    logic                 carry_reg,  carry_next;
    logic                 found_reg,  found_next;
    logic [RES_W-1:0]     best_idx_reg, best_idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [TIME_W-1:0]    avail_reg [MAX_RESOURCES];
    logic [MAX_RESOURCES-1:0] busy_reg, busy_next;

    // ---------------- datapath registers ----------------
    logic                 op_reg;
    logic [3:0]           mask_reg;
    logic [EXEC_W-1:0]    exec_reg [4];
    logic [RIDX_W-1:0]    fin_reg;
    logic [TIME_W-1:0]    a_sr_reg, a_sr_next;     // availability under test
    logic [TIME_W-1:0]    n_sr_reg, n_sr_next;     // present time
    logic [TIME_W-1:0]    e_sr_reg, e_sr_next;     // execution time
    logic [TIME_W-1:0]    ft_sr_reg, ft_sr_next;   // sum being formed
    logic [TIME_W-1:0]    best_sr_reg, best_sr_next;
    logic                 best_hi_reg, best_hi_next; // carry bit of the best sum
    out_item_t            out_data_reg, out_data_next;

    // ---------------- combinational helpers ----------------
    logic                 accept;
    logic                 load_out;
    logic [CNT_W-1:0]     n_start;
    logic [CNT_W-1:0]     cnt_m1;
    logic [RES_W-1:0]     cur_r;
    logic [TYPE_W-1:0]    cur_t;
    logic                 cur_sup;
    logic [EXEC_W-1:0]    cur_exec;
    logic [DIG_W-1:0]     a_d, n_d, e_d, b_d, s_d, sum_d;
    logic [DIG_W:0]       add_w;
    logic                 dig_last;
    logic                 ltb_d;
    logic                 better;
    logic [TIME_W-1:0]    ft_full;
    logic [TIME_W-1:0]    sat_ft;
    logic                 refuse;
    logic [MAX_RESOURCES-1:0] best_bit, fin_bit;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    assign n_start  = (32'(res_in_use_reg) > MAX_RESOURCES) ? CNT_W'(MAX_RESOURCES)
                                                            : CNT_W'(res_in_use_reg);
    assign cnt_m1   = cnt_reg - 1'b1;
    assign cur_r    = cnt_m1[RES_W-1:0];
    assign cur_t    = type_of(type_map_reg, cur_r);
    assign cur_sup  = (32'(cur_t) < NUM_TYPES) && mask_reg[cur_t];
    assign cur_exec = exec_reg[cur_t];

    // low digits of the rotating operands
    assign a_d      = a_sr_reg[DIG_W-1:0];
    assign n_d      = n_sr_reg[DIG_W-1:0];
    assign e_d      = e_sr_reg[DIG_W-1:0];
    assign b_d      = best_sr_reg[DIG_W-1:0];
    assign s_d      = lt_reg ? n_d : a_d;
    assign add_w    = {1'b0, s_d} + {1'b0, e_d} + {{DIG_W{1'b0}}, carry_reg};
    assign sum_d    = add_w[DIG_W-1:0];
    assign dig_last = (32'(dig_reg) == N_DIG - 1);
    assign ft_full  = {sum_d, ft_sr_reg[TIME_W-1:DIG_W]};

    // running sum-below-best compare, this digit included
    assign ltb_d    = (sum_d < b_d) || ((sum_d == b_d) && ltb_reg);

    // strict less-than keeps the earlier (higher-index) resource on a tie
    assign better   = !found_reg
                   || (!add_w[DIG_W] && best_hi_reg)
                   || ((add_w[DIG_W] == best_hi_reg) && ltb_d);

    assign sat_ft   = best_hi_reg ? {TIME_W{1'b1}} : best_sr_reg;
    assign best_bit = MAX_RESOURCES'(1) << best_idx_reg;
    assign fin_bit  = MAX_RESOURCES'(1) << fin_reg;
    assign refuse   = !queue_en_reg && ((busy_reg & best_bit) != '0);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        dig_next       = dig_reg;
        lt_next        = lt_reg;
        ltb_next       = ltb_reg;
        carry_next     = carry_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        busy_next      = busy_reg;
        a_sr_next      = a_sr_reg;
        n_sr_next      = n_sr_reg;
        e_sr_next      = e_sr_reg;
        ft_sr_next     = ft_sr_reg;
        best_sr_next   = best_sr_reg;
        best_hi_next   = best_hi_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    n_sr_next  = in_data.now_time;
                    cnt_next   = n_start;
                    found_next = 1'b0;
                    state_next = (in_data.opcode == OP_FINISH) ? S_DONE : S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (cur_sup)
                begin
                    a_sr_next  = avail_reg[cur_r];
                    e_sr_next  = TIME_W'(cur_exec);
                    dig_next   = '0;
                    lt_next    = 1'b0;
                    state_next = S_CMP;
                end
                else
                begin
                    cnt_next = cnt_m1;
                end
            end
            S_CMP:
            begin
                // compare availability with present time, low digit first
                lt_next   = (a_d < n_d) || ((a_d == n_d) && lt_reg);
                a_sr_next = {a_d, a_sr_reg[TIME_W-1:DIG_W]};
                n_sr_next = {n_d, n_sr_reg[TIME_W-1:DIG_W]};
                dig_next  = dig_reg + 1'b1;
                if (dig_last)
                begin
                    dig_next   = '0;
                    carry_next = 1'b0;
                    ltb_next   = 1'b0;
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                // add one digit of the start time and the execution time
                carry_next   = add_w[DIG_W];
                ltb_next     = ltb_d;
                a_sr_next    = {a_d, a_sr_reg[TIME_W-1:DIG_W]};
                n_sr_next    = {n_d, n_sr_reg[TIME_W-1:DIG_W]};
                e_sr_next    = {e_d, e_sr_reg[TIME_W-1:DIG_W]};
                best_sr_next = {b_d, best_sr_reg[TIME_W-1:DIG_W]};
                ft_sr_next   = ft_full;
                dig_next     = dig_reg + 1'b1;
                if (dig_last)
                begin
                    if (better)
                    begin
                        best_sr_next  = ft_full;
                        best_hi_next  = add_w[DIG_W];
                        best_idx_next = cur_r;
                        found_next    = 1'b1;
                    end
                    cnt_next   = cnt_m1;
                    state_next = S_LOAD;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    if (op_reg == OP_FINISH)
                    begin
                        busy_next                = busy_reg & ~fin_bit;
                        out_data_next.chosen_res = fin_reg;
                    end
                    else if (found_reg)
                    begin
                        out_data_next.chosen_res = RIDX_W'(best_idx_reg);
                        if (!refuse)
                        begin
                            busy_next              = busy_reg | best_bit;
                            out_data_next.assigned = 1'b1;
                            out_data_next.end_time = sat_ft;
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state, configuration and stored availability
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            dig_reg        <= '0;
            lt_reg         <= 1'b0;
            ltb_reg        <= 1'b0;
            carry_reg      <= 1'b0;
            found_reg      <= 1'b0;
            best_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
            busy_reg       <= '0;
            res_in_use_reg <= COUNT_W'(8);
            type_map_reg   <= '0;
            queue_en_reg   <= 1'b1;
            for (int i = 0; i < MAX_RESOURCES; i++)
            begin
                avail_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            dig_reg       <= dig_next;
            lt_reg        <= lt_next;
            ltb_reg       <= ltb_next;
            carry_reg     <= carry_next;
            found_reg     <= found_next;
            best_idx_reg  <= best_idx_next;
            out_valid_reg <= out_valid_next;
            busy_reg      <= busy_next;
            if (load_out && op_reg == OP_SCHEDULE && found_reg && !refuse)
            begin
                avail_reg[best_idx_reg] <= sat_ft;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_RESOURCES_IN_USE:  res_in_use_reg <= cfg_data[COUNT_W-1:0];
                    CFG_RESOURCE_TYPE_MAP: type_map_reg   <= cfg_data[MAP_W-1:0];
                    CFG_QUEUEING_ENABLE:   queue_en_reg   <= cfg_data[0];
                    default:               ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= in_data.opcode;
            mask_reg    <= in_data.supported_mask;
            exec_reg[0] <= in_data.exec_time_type0;
            exec_reg[1] <= in_data.exec_time_type1;
            exec_reg[2] <= in_data.exec_time_type2;
            exec_reg[3] <= in_data.exec_time_type3;
            fin_reg     <= in_data.finished_resource;
        end
        a_sr_reg     <= a_sr_next;
        n_sr_reg     <= n_sr_next;
        e_sr_reg     <= e_sr_next;
        ft_sr_reg    <= ft_sr_next;
        best_sr_reg  <= best_sr_next;
        best_hi_reg  <= best_hi_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------- assertions ----------------
    a_new_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result transfer appeared outside the done step");

    a_assigned_written_back: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (!out_data_reg.assigned
                      || (avail_reg[best_idx_reg] == out_data_reg.end_time
                          && busy_reg[best_idx_reg])))
        else $error("assigned finish time not stored or resource not marked busy");

    a_walk_has_resource: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP || state_reg == S_ADD) |-> cnt_reg != '0)
        else $error("digit pass running with no resource left");

    a_unassigned_zero_time: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.assigned) |-> out_data_reg.end_time == '0)
        else $error("unassigned result carries a finish time");

endmodule
